// ----- src/psmg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package psmg_pkg;

	localparam int MAX_VALUE = 65535;
	localparam int VAL_W     = 16;
	localparam int RAM_DEPTH = MAX_VALUE + 1;
	localparam int ALU_W     = VAL_W + 1;
	localparam int ROOT_W    = 9;

	typedef enum logic [0:0] {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_INIT  = 9'b000000010,
		S_OCHK  = 9'b000000100,
		S_OWAIT = 9'b000001000,
		S_MARK  = 9'b000010000,
		S_ONEXT = 9'b000100000,
		S_SRD   = 9'b001000000,
		S_SCHK  = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

endpackage

`default_nettype wire

// ----- src/psmg_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module psmg_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// ----- src/psmg_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

module psmg_alu (
	input  wire psmg_pkg::alu_op_t              op,
	input  wire logic [psmg_pkg::ALU_W-1:0]     a,
	input  wire logic [psmg_pkg::ALU_W-1:0]     b,
	output logic      [psmg_pkg::ALU_W-1:0]     sum
);

	always_comb begin
		unique case (op)
			psmg_pkg::ALU_ADD: sum = a + b;
			psmg_pkg::ALU_SUB: sum = a - b;
			default:           sum = a + b;
		endcase
	end

endmodule

`default_nettype wire

// ----- src/prime_sieve_max_gap_core.sv -----
// prime_sieve_max_gap_core
// Input channel: low_bound/high_bound, beat taken when in_valid is high and
// in_stall is low. in_stall stays high from the accepted beat until the
// result has been handed to the output register.
// Output channel: largest_gap/range_error, held in an output register until
// the beat is taken (out_valid high, out_stall low). A new request may be
// accepted while that beat still waits.
// Per request: clear/fill pass of the prime bitmap (addresses 0 to
// high_bound), marking of composites (for each base from 2 while its square
// is at most high_bound, a prime base clears its multiples from the square
// up to high_bound), then a scan of every number from low_bound to
// high_bound.
// The bitmap is a single-port 64K x 1 RAM; the multiple step, the square
// update and the gap subtraction go through one shared adder. low_bound
// above high_bound returns range_error without touching the bitmap.
// If out_stall holds the previous beat, the finished result waits inside.
// Reset (arst_n low) returns the sequencer to idle and drops out_valid; the
// bitmap is not cleared and needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module prime_sieve_max_gap_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [psmg_pkg::VAL_W-1:0]  low_bound,
	input  wire logic [psmg_pkg::VAL_W-1:0]  high_bound,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [psmg_pkg::VAL_W-1:0]  largest_gap,
	output logic                             range_error
);

	localparam int VW = psmg_pkg::VAL_W;
	localparam int AW = psmg_pkg::ALU_W;
	localparam int RW = psmg_pkg::ROOT_W;

	psmg_pkg::state_t state_q;

	logic [VW-1:0] lo_q, hi_q, idx_q, v_q, last_q, best_q;
	logic          have_q, err_q;
	logic [RW-1:0] i_q;
	logic [AW-1:0] sq_q, j_q;

	logic [VW-1:0] gap_q, gap_out_q;
	logic          out_valid_q, err_out_q;

	psmg_pkg::alu_op_t alu_op;
	logic [AW-1:0]     alu_a, alu_b, alu_sum;

	logic          ram_we;
	logic [VW-1:0] ram_addr;
	logic [0:0]    ram_wdata, ram_rdata;

	logic [VW-1:0] gap;
	logic          out_load;

	psmg_ram #(
		.WIDTH(1),
		.DEPTH(psmg_pkg::RAM_DEPTH)
	) u_bits (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	psmg_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.sum (alu_sum)
	);

	assign gap = alu_sum[VW-1:0];

	always_comb begin
		alu_op = psmg_pkg::ALU_ADD;
		alu_a  = j_q;
		alu_b  = {{(AW-RW){1'b0}}, i_q};
		unique case (state_q)
			psmg_pkg::S_ONEXT: begin
				alu_a = sq_q;
				alu_b = {{(AW-RW-1){1'b0}}, i_q, 1'b1};
			end
			psmg_pkg::S_SCHK: begin
				alu_op = psmg_pkg::ALU_SUB;
				alu_a  = {1'b0, v_q};
				alu_b  = {1'b0, last_q};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = v_q;
		ram_wdata = 1'b0;
		unique case (state_q)
			psmg_pkg::S_INIT: begin
				ram_we    = 1'b1;
				ram_addr  = idx_q;
				ram_wdata = (idx_q >= VW'(2)) ? 1'b1 : 1'b0;
			end
			psmg_pkg::S_OCHK: begin
				ram_addr = {{(VW-RW){1'b0}}, i_q};
			end
			psmg_pkg::S_MARK: begin
				ram_we   = (j_q <= {1'b0, hi_q});
				ram_addr = j_q[VW-1:0];
			end
			default: begin
			end
		endcase
	end

	assign in_stall = (state_q != psmg_pkg::S_IDLE);
	assign out_load = (state_q == psmg_pkg::S_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psmg_pkg::S_IDLE;
			v_q     <= '0;
			best_q  <= '0;
		end else begin
			unique case (state_q)
				psmg_pkg::S_IDLE: begin
					if (in_valid) begin
						lo_q  <= low_bound;
						hi_q  <= high_bound;
						idx_q <= '0;
						if (low_bound > high_bound) begin
							err_q   <= 1'b1;
							gap_q   <= '0;
							state_q <= psmg_pkg::S_DONE;
						end else begin
							err_q   <= 1'b0;
							state_q <= psmg_pkg::S_INIT;
						end
					end
				end
				psmg_pkg::S_INIT: begin
					if (idx_q == hi_q) begin
						i_q     <= RW'(2);
						sq_q    <= AW'(4);
						state_q <= psmg_pkg::S_OCHK;
					end else begin
						idx_q <= idx_q + VW'(1);
					end
				end
				psmg_pkg::S_OCHK: begin
					if (sq_q > {1'b0, hi_q}) begin
						v_q     <= lo_q;
						last_q  <= '0;
						have_q  <= 1'b0;
						best_q  <= '0;
						state_q <= psmg_pkg::S_SRD;
					end else begin
						state_q <= psmg_pkg::S_OWAIT;
					end
				end
				psmg_pkg::S_OWAIT: begin
					j_q     <= sq_q;
					state_q <= ram_rdata[0] ? psmg_pkg::S_MARK : psmg_pkg::S_ONEXT;
				end
				psmg_pkg::S_MARK: begin
					if (j_q > {1'b0, hi_q}) begin
						state_q <= psmg_pkg::S_ONEXT;
					end else begin
						j_q <= alu_sum;
					end
				end
				psmg_pkg::S_ONEXT: begin
					sq_q    <= alu_sum;
					i_q     <= i_q + RW'(1);
					state_q <= psmg_pkg::S_OCHK;
				end
				psmg_pkg::S_SRD: begin
					state_q <= psmg_pkg::S_SCHK;
				end
				psmg_pkg::S_SCHK: begin
					if (ram_rdata[0]) begin
						if (have_q && (gap > VW'(1)) && (gap > best_q)) begin
							best_q <= gap;
							gap_q  <= gap;
						end else begin
							gap_q <= best_q;
						end
						last_q <= v_q;
						have_q <= 1'b1;
					end else begin
						gap_q <= best_q;
					end
					if (v_q == hi_q) begin
						state_q <= psmg_pkg::S_DONE;
					end else begin
						v_q     <= v_q + VW'(1);
						state_q <= psmg_pkg::S_SRD;
					end
				end
				psmg_pkg::S_DONE: begin
					if (out_load) begin
						state_q <= psmg_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= psmg_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			gap_out_q <= gap_q;
			err_out_q <= err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign largest_gap = gap_out_q;
	assign range_error = err_out_q;

endmodule

`default_nettype wire

// ----- bench/tb_prime_sieve_max_gap_core.sv -----
`timescale 1ns / 1ps

module tb_prime_sieve_max_gap_core;
	import psmg_pkg::*;

	typedef struct {
		logic [VAL_W-1:0] low;
		logic [VAL_W-1:0] high;
		bit               drain;
		int unsigned      phase;
	} bound_req_t;

	typedef struct {
		logic [VAL_W-1:0] gap;
		logic             err;
	} gap_result_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [VAL_W-1:0] low_bound;
	logic [VAL_W-1:0] high_bound;
	logic             out_valid;
	logic             out_stall;
	logic [VAL_W-1:0] largest_gap;
	logic             range_error;

	bound_req_t  req_q [$];
	gap_result_t gap_q [$];

	// sender idle and receiver stall percentages per phase
	int unsigned idle_pct  [4] = '{0, 70, 0, 31};
	int unsigned stall_pct [4] = '{0, 0, 70, 31};
	int unsigned cur_phase = 0;

	bit               prime_map [RAM_DEPTH];
	logic [VAL_W-1:0] last_scan_top = '0;
	logic [VAL_W-1:0] last_best = '0;
	bit               in_took = 1'b0;
	int unsigned      fail_count = 0;

	prime_sieve_max_gap_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.low_bound   (low_bound),
		.high_bound  (high_bound),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.largest_gap (largest_gap),
		.range_error (range_error)
	);

	always #5 clk = ~clk;

	function automatic gap_result_t predict_gap(input logic [VAL_W-1:0] lo,
		input logic [VAL_W-1:0] hi);
		gap_result_t res;
		int          limit;
		int          i;
		int          j;
		int          prev;
		int          best;
		bit          have_prev;
		res.gap   = '0;
		res.err   = 1'b0;
		best      = 0;
		prev      = 0;
		have_prev = 1'b0;
		if (lo > hi) begin
			res.err = 1'b1;
			return res;
		end
		limit = (hi > MAX_VALUE) ? MAX_VALUE : int'(hi);
		for (i = 0; i <= limit; i++)
			prime_map[i] = (i >= 2);
		for (i = 2; i * i <= limit; i++) begin
			if (prime_map[i]) begin
				for (j = i * i; j <= limit; j += i)
					prime_map[j] = 1'b0;
			end
		end
		for (i = int'(lo); i <= limit; i++) begin
			if (prime_map[i]) begin
				if (have_prev && (i - prev) > 1 && (i - prev) > best)
					best = i - prev;
				prev      = i;
				have_prev = 1'b1;
			end
		end
		last_scan_top = limit[VAL_W-1:0];
		last_best     = best[VAL_W-1:0];
		res.gap       = best[VAL_W-1:0];
		return res;
	endfunction

	task automatic add_req(input int lo, input int hi, input bit drain,
		input int unsigned phase);
		bound_req_t r;
		r.low   = lo[VAL_W-1:0];
		r.high  = hi[VAL_W-1:0];
		r.drain = drain;
		r.phase = phase;
		req_q.push_back(r);
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_took) begin
				if (req_q.size() != 0 && !(req_q[0].drain && gap_q.size() != 0) &&
				    $urandom_range(0, 99) >= idle_pct[req_q[0].phase]) begin
					in_valid   <= 1'b1;
					low_bound  <= req_q[0].low;
					high_bound <= req_q[0].high;
					cur_phase  = req_q[0].phase;
					req_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct[cur_phase]);
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		gap_result_t exp_res;
		if (!arst_n) begin
			in_took <= 1'b0;
		end else begin
			in_took <= in_valid && !in_stall;
			if (in_valid && !in_stall)
				gap_q.push_back(predict_gap(low_bound, high_bound));
			if (out_valid && !out_stall) begin
				if (gap_q.size() == 0) begin
					$display("%0t: unexpected beat largest_gap=%0d range_error=%0b",
						$time, largest_gap, range_error);
					fail_count++;
				end else begin
					exp_res = gap_q.pop_front();
					if (largest_gap !== exp_res.gap) begin
						$display("%0t: largest_gap expected %0d actual %0d",
							$time, exp_res.gap, largest_gap);
						fail_count++;
					end
					if (range_error !== exp_res.err) begin
						$display("%0t: range_error expected %0b actual %0b",
							$time, exp_res.err, range_error);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		int          n;
		int          r;
		int          lo;
		int          hi;
		int unsigned ph;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		low_bound  = '0;
		high_bound = '0;
		out_stall  = 1'b0;

		add_req(0, 0, 0, 0);
		add_req(0, 1, 0, 0);
		add_req(1, 1, 0, 0);
		add_req(0, 2, 0, 0);
		add_req(2, 3, 0, 0);
		add_req(2, 5, 0, 0);
		add_req(0, 10, 0, 0);
		add_req(7, 7, 0, 0);
		add_req(8, 10, 0, 0);
		add_req(10, 9, 0, 0);
		add_req(19, 28, 0, 0);
		add_req(23, 28, 0, 0);
		add_req(113, 127, 0, 0);
		add_req(65535, 0, 0, 0);
		add_req(1, 0, 0, 0);
		add_req(0, 65535, 1, 0);
		add_req(65535, 65534, 0, 0);
		add_req(3, 1000, 0, 0);

		for (ph = 0; ph < 4; ph++) begin
			for (n = 0; n < 25; n++) begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					hi = $urandom_range(0, 65534);
					lo = $urandom_range(hi + 1, 65535);
				end else if (r < 20) begin
					hi = $urandom_range(0, 3000);
					lo = $urandom_range(0, hi);
				end else begin
					hi = $urandom_range(0, 600);
					lo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, hi)
						: $urandom_range(0, hi / 8);
				end
				add_req(lo, hi, (n == 0) || ($urandom_range(0, 99) < 5), ph);
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (req_q.size() == 0 && !in_valid);
		wait (gap_q.size() == 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_prime_sieve_max_gap_core passed");
		end else begin
			$display("tb_prime_sieve_max_gap_core failed");
		end
		$finish;
	end

	initial begin
		#100_000_000;
		$display("tb_prime_sieve_max_gap_core failed");
		$finish;
	end

endmodule

// ----- prime_sieve_max_gap_core.f -----
src/psmg_pkg.sv
src/psmg_ram.sv
src/psmg_alu.sv
src/prime_sieve_max_gap_core.sv
bench/tb_prime_sieve_max_gap_core.sv
